>>> hw/rtl/tlssni_pkg.sv
package tlssni_pkg;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_HEAD  = 4'd1,
        PH_SID   = 4'd2,
        PH_CS_HI = 4'd3,
        PH_CS_LO = 4'd4,
        PH_COMP  = 4'd5,
        PH_ET_HI = 4'd6,
        PH_ET_LO = 4'd7,
        PH_XT_HI = 4'd8,
        PH_XT_LO = 4'd9,
        PH_XL_HI = 4'd10,
        PH_XL_LO = 4'd11,
        PH_N_HI  = 4'd12,
        PH_N_LO  = 4'd13,
        PH_NAME  = 4'd14,
        PH_DONE  = 4'd15
    } phase_t;

    localparam int          DEFAULT_NAME_BUF  = 128;
    localparam logic [7:0]  CT_HANDSHAKE      = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO   = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME   = 16'h0000;
    localparam logic [15:0] MIN_RECORD_LEN    = 16'd44;
    localparam logic [17:0] SID_LEN_POS       = 18'd43;
    localparam logic [17:0] HS_TYPE_POS       = 18'd5;
    localparam logic [17:0] POS_MAX           = 18'h3FFFF;
    localparam logic [15:0] SNI_MIN_EXT_LEN   = 16'd5;

endpackage

>>> hw/rtl/tls_client_hello_sni_extract.sv
// Transfers pass the input register, then the result register. Throughput:
// one payload byte per cycle while m_tready does not stall the output; the
// parser is a single registered step between the input and result registers.
// Reset: asynchronous active-low rst_n clears the parser to idle and empties
// both registers; bytes before the first start of payload give no result.
module tls_client_hello_sni_extract #(
    parameter int NAME_BUF = tlssni_pkg::DEFAULT_NAME_BUF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] payload_length
    input  logic        s_tuser,   // [0] start_of_payload
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] name_byte
    output logic        m_tuser,   // [0] found
    output logic        m_tlast
);

    localparam int NL_W = (NAME_BUF > 2) ? $clog2(NAME_BUF) : 1;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic [15:0] in_len_reg;

    // parser state
    tlssni_pkg::phase_t phase_reg, phase_next;
    logic [17:0]        pos_reg, pos_next;
    logic [15:0]        len_reg, len_next;
    logic [17:0]        nfp_reg, nfp_next;
    logic [8:0]         acc_reg, acc_next;
    logic [15:0]        ext_end_reg, ext_end_next;
    logic [15:0]        cur_end_reg, cur_end_next;
    logic [NL_W-1:0]    nbl_reg, nbl_next;
    logic               fin_reg, fin_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_found_reg;
    logic       out_last_reg;

    logic       fire;
    logic       res_valid;
    logic [7:0] res_byte;
    logic       res_found;
    logic       res_last;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata[7:0];
            in_len_reg   <= s_tdata[23:8];
            in_start_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tlssni_pkg::PH_IDLE;
            pos_reg     <= '0;
            len_reg     <= '0;
            nfp_reg     <= '0;
            acc_reg     <= '0;
            ext_end_reg <= '0;
            cur_end_reg <= '0;
            nbl_reg     <= '0;
            fin_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            nfp_reg     <= nfp_next;
            acc_reg     <= acc_next;
            ext_end_reg <= ext_end_next;
            cur_end_reg <= cur_end_next;
            nbl_reg     <= nbl_next;
            fin_reg     <= fin_next;
        end
    end

    always_comb
    begin
        logic [19:0] p20;
        logic [19:0] b20;
        logic [19:0] len20;
        logic [19:0] n20;
        logic [19:0] s20;
        logic [19:0] se20;
        logic [15:0] w16;
        logic [15:0] ext_v;
        logic        active;
        logic [NL_W-1:0] nbl_dec;

        phase_next   = phase_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        nfp_next     = nfp_reg;
        acc_next     = acc_reg;
        ext_end_next = ext_end_reg;
        cur_end_next = cur_end_reg;
        nbl_next     = nbl_reg;
        fin_next     = fin_reg;
        res_valid    = 1'b0;
        res_byte     = 8'd0;
        res_found    = 1'b0;
        res_last     = 1'b0;
        p20   = '0;
        b20   = '0;
        len20 = '0;
        n20   = '0;
        s20   = '0;
        se20  = '0;
        w16   = '0;
        ext_v = '0;
        active  = 1'b0;
        nbl_dec = '0;

        if (fire)
        begin
            if (in_start_reg)
            begin
                len_next = in_len_reg;
                pos_next = '0;
                fin_next = 1'b0;
                nbl_next = '0;
                acc_next = '0;
                nfp_next = tlssni_pkg::SID_LEN_POS;
                phase_next = (in_len_reg < tlssni_pkg::MIN_RECORD_LEN)
                           ? tlssni_pkg::PH_DONE : tlssni_pkg::PH_HEAD;
            end

            active = (phase_next != tlssni_pkg::PH_IDLE)
                  && !(phase_next == tlssni_pkg::PH_DONE && fin_next);

            p20   = {2'b00, pos_next};
            b20   = {12'd0, in_byte_reg};
            len20 = {4'd0, len_next};
            w16   = {acc_next[7:0], in_byte_reg};
            s20   = p20 + 20'd1;

            if (active)
            begin
                case (phase_next)
                    tlssni_pkg::PH_HEAD:
                    begin
                        if (pos_next == '0 && in_byte_reg != tlssni_pkg::CT_HANDSHAKE)
                        begin
                            phase_next = tlssni_pkg::PH_DONE;
                            fin_next   = 1'b0;
                        end
                        else if (pos_next == tlssni_pkg::HS_TYPE_POS)
                        begin
                            if (in_byte_reg != tlssni_pkg::HS_CLIENT_HELLO)
                            begin
                                phase_next = tlssni_pkg::PH_DONE;
                                fin_next   = 1'b0;
                            end
                            else
                            begin
                                phase_next = tlssni_pkg::PH_SID;
                            end
                        end
                    end
                    tlssni_pkg::PH_NAME:
                    begin
                        nbl_dec   = nbl_next - NL_W'(1);
                        nbl_next  = nbl_dec;
                        res_valid = 1'b1;
                        res_byte  = in_byte_reg;
                        res_found = 1'b1;
                        res_last  = (nbl_dec == '0);
                        if (nbl_dec == '0)
                        begin
                            phase_next = tlssni_pkg::PH_DONE;
                            fin_next   = 1'b1;
                        end
                    end
                    tlssni_pkg::PH_DONE:
                    begin
                        phase_next = tlssni_pkg::PH_DONE;
                    end
                    default:
                    begin
                        if (pos_next == nfp_next)
                        begin
                            case (phase_next)
                                tlssni_pkg::PH_SID,
                                tlssni_pkg::PH_COMP:
                                begin
                                    n20 = s20 + b20;
                                    if (n20 + 20'd2 > len20)
                                    begin
                                        phase_next = tlssni_pkg::PH_DONE;
                                        fin_next   = 1'b0;
                                    end
                                    else
                                    begin
                                        nfp_next   = n20[17:0];
                                        phase_next = (phase_next == tlssni_pkg::PH_SID)
                                                   ? tlssni_pkg::PH_CS_HI
                                                   : tlssni_pkg::PH_ET_HI;
                                    end
                                end
                                tlssni_pkg::PH_CS_HI,
                                tlssni_pkg::PH_ET_HI,
                                tlssni_pkg::PH_XT_HI,
                                tlssni_pkg::PH_N_HI:
                                begin
                                    acc_next   = {1'b0, in_byte_reg};
                                    nfp_next   = s20[17:0];
                                    phase_next = tlssni_pkg::phase_t'(phase_next + 4'd1);
                                end
                                tlssni_pkg::PH_CS_LO:
                                begin
                                    n20 = s20 + {4'd0, w16};
                                    if (n20 + 20'd1 > len20)
                                    begin
                                        phase_next = tlssni_pkg::PH_DONE;
                                        fin_next   = 1'b0;
                                    end
                                    else
                                    begin
                                        nfp_next   = n20[17:0];
                                        phase_next = tlssni_pkg::PH_COMP;
                                    end
                                end
                                tlssni_pkg::PH_ET_LO:
                                begin
                                    n20   = s20 + {4'd0, w16};
                                    ext_v = (n20 > len20) ? len_next : n20[15:0];
                                    ext_end_next = ext_v;
                                    if (s20 + 20'd4 > {4'd0, ext_v})
                                    begin
                                        phase_next = tlssni_pkg::PH_DONE;
                                        fin_next   = 1'b0;
                                    end
                                    else
                                    begin
                                        nfp_next   = s20[17:0];
                                        phase_next = tlssni_pkg::PH_XT_HI;
                                    end
                                end
                                tlssni_pkg::PH_XT_LO:
                                begin
                                    acc_next   = {8'd0, w16 == tlssni_pkg::EXT_SERVER_NAME};
                                    nfp_next   = s20[17:0];
                                    phase_next = tlssni_pkg::PH_XL_HI;
                                end
                                tlssni_pkg::PH_XL_HI:
                                begin
                                    acc_next   = {acc_next[0], in_byte_reg};
                                    nfp_next   = s20[17:0];
                                    phase_next = tlssni_pkg::PH_XL_LO;
                                end
                                tlssni_pkg::PH_XL_LO:
                                begin
                                    se20 = s20 + {4'd0, w16};
                                    if (se20 > {4'd0, ext_end_next})
                                    begin
                                        phase_next = tlssni_pkg::PH_DONE;
                                        fin_next   = 1'b0;
                                    end
                                    else
                                    begin
                                        cur_end_next = se20[15:0];
                                        if (acc_next[8] && w16 >= tlssni_pkg::SNI_MIN_EXT_LEN)
                                        begin
                                            n20        = s20 + 20'd3;
                                            nfp_next   = n20[17:0];
                                            phase_next = tlssni_pkg::PH_N_HI;
                                        end
                                        else if (se20 + 20'd4 > {4'd0, ext_end_next})
                                        begin
                                            phase_next = tlssni_pkg::PH_DONE;
                                            fin_next   = 1'b0;
                                        end
                                        else
                                        begin
                                            nfp_next   = se20[17:0];
                                            phase_next = tlssni_pkg::PH_XT_HI;
                                        end
                                    end
                                end
                                tlssni_pkg::PH_N_LO:
                                begin
                                    se20 = s20 + {4'd0, w16};
                                    if (se20 <= {4'd0, cur_end_next}
                                        && {1'b0, w16} < 17'(NAME_BUF))
                                    begin
                                        if (w16 == '0)
                                        begin
                                            phase_next = tlssni_pkg::PH_DONE;
                                            fin_next   = 1'b1;
                                        end
                                        else
                                        begin
                                            nbl_next   = w16[NL_W-1:0];
                                            nfp_next   = s20[17:0];
                                            phase_next = tlssni_pkg::PH_NAME;
                                        end
                                    end
                                    else if ({4'd0, cur_end_next} + 20'd4
                                             > {4'd0, ext_end_next})
                                    begin
                                        phase_next = tlssni_pkg::PH_DONE;
                                        fin_next   = 1'b0;
                                    end
                                    else
                                    begin
                                        nfp_next   = {2'b00, cur_end_next};
                                        phase_next = tlssni_pkg::PH_XT_HI;
                                    end
                                end
                                default:
                                begin
                                    phase_next = phase_next;
                                end
                            endcase
                        end
                    end
                endcase

                // final byte with nothing found
                if (!res_valid && !fin_next && s20 >= len20)
                begin
                    res_valid  = 1'b1;
                    res_byte   = 8'd0;
                    res_found  = 1'b0;
                    res_last   = 1'b1;
                    phase_next = tlssni_pkg::PH_DONE;
                    fin_next   = 1'b1;
                end

                if (pos_next < tlssni_pkg::POS_MAX)
                begin
                    pos_next = pos_next + 18'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_byte_reg  <= res_byte;
            out_found_reg <= res_found;
            out_last_reg  <= res_last;
        end
    end

endmodule
